// File: src/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

   // display geometry
   localparam int DIGIT_COUNT = 3;
   localparam int DIGIT_SLOTS = 3;

   // frame queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // register indexes of the csr port
   localparam logic [1:0] REG_PERIOD   = 2'd0;
   localparam logic [1:0] REG_EXP_ADDR = 2'd1;
   localparam logic [1:0] REG_OUT_REG  = 2'd2;

   // reset values of the registers
   localparam logic [15:0] PERIOD_RESET   = 16'd2500;
   localparam logic [7:0]  EXP_ADDR_RESET = 8'd64;
   localparam logic [7:0]  OUT_REG_RESET  = 8'd2;

   // byte slots of one expander write frame
   localparam logic [1:0] SLOT_ADDRESS  = 2'd0;
   localparam logic [1:0] SLOT_REGISTER = 2'd1;
   localparam logic [1:0] SLOT_PATTERN  = 2'd2;
   localparam logic [1:0] SLOT_SELECT   = 2'd3;

   localparam logic [7:0] SIGN_BIT    = 8'h08;
   localparam logic [7:0] BLANK_SEGS  = 8'hFF;
   localparam logic [9:0] MAG_LIMIT   = 10'd999;

   typedef struct packed {
      logic              mode;
      logic signed [15:0] new_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_start;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] multiplex_period;
      logic [7:0]  expander_address;
      logic [7:0]  output_register;
   } cfg_type;

   // per-frame payload that depends on the display contents
   typedef struct packed {
      logic [7:0] pattern;
      logic [7:0] select;
   } frame_type;

   // active-low segment pattern of one decimal digit
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] segs;
      case (digit)
         4'd0:    segs = 8'h03;
         4'd1:    segs = 8'h9F;
         4'd2:    segs = 8'h25;
         4'd3:    segs = 8'h0D;
         4'd4:    segs = 8'h99;
         4'd5:    segs = 8'h49;
         4'd6:    segs = 8'h41;
         4'd7:    segs = 8'h1F;
         4'd8:    segs = 8'h01;
         4'd9:    segs = 8'h09;
         default: segs = BLANK_SEGS;
      endcase
      return segs;
   endfunction

endpackage

`default_nettype wire

// File: src/ssm_front.sv
`default_nettype none

module ssm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  ssm_pkg::req_type        req_data,
   input  ssm_pkg::cfg_type        cfg,
   input  wire logic               q_full,
   output logic                    q_push,
   output ssm_pkg::frame_type      q_data
);

   typedef struct packed {
      logic       load;
      logic       neg;
      logic [9:0] mag;
      logic       fire;
      logic [1:0] idx;
   } s1_type;

   typedef struct packed {
      logic       load;
      logic       neg;
      logic [3:0] hund;
      logic [6:0] rem;
      logic       fire;
      logic [1:0] idx;
   } s2_type;

   typedef struct packed {
      logic       load;
      logic       neg;
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
      logic       fire;
      logic [1:0] idx;
   } s3_type;

   logic        en;
   logic        accept;

   logic [15:0] tick_count_ff, tick_count_in;
   logic [1:0]  digit_index_ff, digit_index_in;
   logic        neg_ff, neg_in;
   logic [3:0]  digits_ff [ssm_pkg::DIGIT_SLOTS];
   logic [3:0]  digits_in [ssm_pkg::DIGIT_SLOTS];

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        s3_valid_ff, s3_valid_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;

   logic [16:0] next_count;
   logic        fire;
   logic [15:0] abs_val;
   logic [15:0] hund_prod;
   logic [9:0]  hund_back;
   logic [13:0] tens_prod;
   logic [6:0]  tens_back;
   logic [3:0]  shown_digit;

   // whole pipe moves unless a frame waits on a full queue
   assign en        = !(s3_valid_ff && s3_ff.fire && q_full);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // tick counting and digit stepping happen at accept
   always_comb begin
      next_count     = {1'b0, tick_count_ff} + 17'd1;
      fire           = next_count > {1'b0, cfg.multiplex_period};
      tick_count_in  = tick_count_ff;
      digit_index_in = digit_index_ff;
      if (accept && req_data.mode == ssm_pkg::MODE_TICK) begin
         if (fire) begin
            tick_count_in = '0;
            if (digit_index_ff >= 2'(ssm_pkg::DIGIT_COUNT - 1)) begin
               digit_index_in = '0;
            end else begin
               digit_index_in = digit_index_ff + 2'd1;
            end
         end else begin
            tick_count_in = next_count[15:0];
         end
      end
   end

   // stage 1: sign and saturated magnitude
   always_comb begin
      abs_val = req_data.new_value[15] ? (~req_data.new_value + 16'd1)
                                       : req_data.new_value;
      s1_in.load = (req_data.mode == ssm_pkg::MODE_LOAD);
      s1_in.neg  = req_data.new_value[15];
      s1_in.mag  = (abs_val > 16'(ssm_pkg::MAG_LIMIT)) ? ssm_pkg::MAG_LIMIT
                                                        : abs_val[9:0];
      s1_in.fire = (req_data.mode == ssm_pkg::MODE_TICK) && fire;
      s1_in.idx  = digit_index_ff;
   end

   // stage 2: hundreds by reciprocal multiply, exact below 1000
   always_comb begin
      hund_prod     = 16'(s1_ff.mag) * 16'd41;
      s2_in.load    = s1_ff.load;
      s2_in.neg     = s1_ff.neg;
      s2_in.hund    = hund_prod[15:12];
      hund_back     = 10'(s2_in.hund) * 10'd100;
      s2_in.rem     = 7'(s1_ff.mag - hund_back);
      s2_in.fire    = s1_ff.fire;
      s2_in.idx     = s1_ff.idx;
   end

   // stage 3: tens and units of the remainder
   always_comb begin
      tens_prod   = 14'(s2_ff.rem) * 14'd103;
      s3_in.load  = s2_ff.load;
      s3_in.neg   = s2_ff.neg;
      s3_in.hund  = s2_ff.hund;
      s3_in.tens  = tens_prod[13:10];
      tens_back   = 7'(s3_in.tens) * 7'd10;
      s3_in.units = 4'(s2_ff.rem - tens_back);
      s3_in.fire  = s2_ff.fire;
      s3_in.idx   = s2_ff.idx;
   end

   assign s1_valid_in = en ? accept      : s1_valid_ff;
   assign s2_valid_in = en ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en ? s2_valid_ff : s3_valid_ff;

   // pipe exit: loads update the display, firing ticks push a frame
   always_comb begin
      neg_in    = neg_ff;
      digits_in = digits_ff;
      if (en && s3_valid_ff && s3_ff.load) begin
         neg_in       = s3_ff.neg;
         digits_in[0] = s3_ff.hund;
         digits_in[1] = s3_ff.tens;
         digits_in[2] = s3_ff.units;
      end
   end

   always_comb begin
      case (s3_ff.idx)
         2'd0:    shown_digit = digits_ff[0];
         2'd1:    shown_digit = digits_ff[1];
         2'd2:    shown_digit = digits_ff[2];
         default: shown_digit = 4'd0;
      endcase
   end

   assign q_push         = en && s3_valid_ff && s3_ff.fire;
   assign q_data.pattern = ssm_pkg::seg_pattern(shown_digit);
   assign q_data.select  = (8'd1 << s3_ff.idx) | (neg_ff ? ssm_pkg::SIGN_BIT : 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         digit_index_ff <= '0;
         neg_ff         <= 1'b0;
         digits_ff      <= '{default: '0};
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
      end else begin
         tick_count_ff  <= tick_count_in;
         digit_index_ff <= digit_index_in;
         neg_ff         <= neg_in;
         digits_ff      <= digits_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s3_valid_ff    <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

`ifndef SYNTH
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      digit_index_ff < 2'(ssm_pkg::DIGIT_COUNT))
      else $error("digit index out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.fire && q_full) |=> (s3_valid_ff && s3_ff.fire && $stable(s3_ff)))
      else $error("blocked frame left the pipe");

   a_load_no_push: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.load) |-> !q_push)
      else $error("load pushed a frame");
`endif

endmodule

`default_nettype wire

// File: src/ssm_queue.sv
`default_nettype none

module ssm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  ssm_pkg::frame_type      push_data,
   input  wire logic               pop,
   output ssm_pkg::frame_type      head,
   output logic                    not_empty,
   output logic                    full
);

   ssm_pkg::frame_type               entry_ff [ssm_pkg::QUEUE_DEPTH];
   logic [ssm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ssm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ssm_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == ssm_pkg::QCNT_W'(ssm_pkg::QUEUE_DEPTH));
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// File: src/ssm_back.sv
`default_nettype none

module ssm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  ssm_pkg::cfg_type        cfg,
   input  ssm_pkg::frame_type      q_head,
   input  wire logic               q_not_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ssm_pkg::rsp_type        rsp_data
);

   logic             slot_ff, slot_unused;
   logic [1:0]       byte_ff, byte_in;
   logic             valid_ff, valid_in;
   ssm_pkg::rsp_type data_ff, data_in;
   logic             load_ok;
   logic             load;

   assign slot_unused = 1'b0;
   assign load_ok = !valid_ff || !rsp_stall;
   assign load    = load_ok && q_not_empty;
   assign q_pop   = load && (byte_ff == ssm_pkg::SLOT_SELECT);

   always_comb begin
      data_in  = data_ff;
      byte_in  = byte_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = byte_ff + 2'd1;
         unique case (byte_ff)
            ssm_pkg::SLOT_ADDRESS:  data_in = '{cfg.expander_address, 1'b1, 1'b0};
            ssm_pkg::SLOT_REGISTER: data_in = '{cfg.output_register, 1'b0, 1'b0};
            ssm_pkg::SLOT_PATTERN:  data_in = '{q_head.pattern, 1'b0, 1'b0};
            ssm_pkg::SLOT_SELECT:   data_in = '{q_head.select, 1'b0, 1'b1};
            default:                data_in = data_ff;
         endcase
      end else if (load_ok) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff  <= '0;
         valid_ff <= 1'b0;
         slot_ff  <= 1'b0;
      end else begin
         byte_ff  <= byte_in;
         valid_ff <= valid_in;
         slot_ff  <= slot_unused;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff & ~slot_ff;
   assign rsp_data  = data_ff;

`ifndef SYNTH
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (load && byte_ff == ssm_pkg::SLOT_SELECT))
      else $error("frame popped before its last byte");

   a_frame_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.frame_last) |=> rsp_valid)
      else $error("gap inside a frame");

   a_start_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_start) |-> (byte_ff == ssm_pkg::SLOT_REGISTER))
      else $error("frame start out of place");
`endif

endmodule

`default_nettype wire

// File: src/seven_segment_multiplex_driver.sv
// three-digit signed seven-segment display driver behind a bus port expander
// request channel (req_valid / req_stall / req_data): mode 0 is one timer
//   tick, mode 1 loads new_value; a value's magnitude saturates to 999
// response channel (rsp_valid / rsp_stall / rsp_data): bytes for the
//   expander, four per refresh frame: address, register, active-low segment
//   pattern, digit select with the sign in bit 3; frame_start marks the
//   first byte and frame_last the fourth
// a tick that pushes the count past multiplex_period emits one frame for
//   the current digit and steps to the next digit
// throughput: one request per cycle while req_stall is low; each frame
//   takes four response bytes through the one-byte output register
// path: three conversion stages, then the frame queue and output byte register
// up to four frames wait in the queue; when it is full and a frame waits at
//   the pipe exit, req_stall rises and the whole front pipe holds; a
//   stalled response byte holds until taken
// reset: count, digit index, sign and digits clear, registers return to
//   period 2500, expander address 64, output register 2; no clearing pass
// csr port: APB-style, registers at byte addresses 0, 4 and 8, always ready
`default_nettype none

module seven_segment_multiplex_driver (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  ssm_pkg::req_type  req_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output ssm_pkg::rsp_type  rsp_data,
   // csr port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   ssm_pkg::cfg_type   cfg_ff, cfg_in;
   logic               csr_write;
   logic [1:0]         csr_index;

   ssm_pkg::frame_type push_data;
   ssm_pkg::frame_type head;
   logic               push;
   logic               pop;
   logic               not_empty;
   logic               full;

   // csr: register index is the word address
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            ssm_pkg::REG_PERIOD:   cfg_in.multiplex_period = csr_pwdata[15:0];
            ssm_pkg::REG_EXP_ADDR: cfg_in.expander_address = csr_pwdata[7:0];
            ssm_pkg::REG_OUT_REG:  cfg_in.output_register  = csr_pwdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ssm_pkg::REG_PERIOD:   csr_prdata = {16'd0, cfg_ff.multiplex_period};
         ssm_pkg::REG_EXP_ADDR: csr_prdata = {24'd0, cfg_ff.expander_address};
         ssm_pkg::REG_OUT_REG:  csr_prdata = {24'd0, cfg_ff.output_register};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.multiplex_period <= ssm_pkg::PERIOD_RESET;
         cfg_ff.expander_address <= ssm_pkg::EXP_ADDR_RESET;
         cfg_ff.output_register  <= ssm_pkg::OUT_REG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: tick counting, value conversion, frame classification
   ssm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (full),
      .q_push    (push),
      .q_data    (push_data)
   );

   // frames waiting for the serializer
   ssm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   // back: four bytes per frame through the output register
   ssm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_head      (head),
      .q_not_empty (not_empty),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
